### sv/psid_pkg.sv
// Package for the per-source sequence id table: sizes, codes and the table entry type.
// No dependencies.
package psid_pkg;

    localparam int CAPACITY = 4096;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_USED  = 2'd1,
        TAG_TOMB  = 2'd2
    } tag_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_ZERO_SOURCE = 2'd1,
        ST_FULL        = 2'd2
    } status_t;

    typedef enum logic {
        FUNC_REQUEST = 1'b0,
        FUNC_REMOVE  = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_PROBE = 2'd2,
        S_CHECK = 2'd3
    } fsm_t;

    typedef struct packed {
        tag_t        tag;
        logic [31:0] key;
        logic [31:0] count;
    } entry_t;

    // Home slot of a source: fold the 32-bit key down to the index width.
    function automatic logic [IDX_W-1:0] home_slot(input logic [31:0] key);
        logic [31:0] f;
        f = key ^ (key >> IDX_W) ^ (key >> (2 * IDX_W));
        return f[IDX_W-1:0];
    endfunction

endpackage

### sv/per_source_sequence_id_table.sv
// Top level of the per-source sequence id table: sequencer, entry memory, result register.
// Depends on psid_pkg.
//
// Issue a transaction by raising start while busy is low. A request (func 0) returns one
// result on event_id/status, marked by a one-cycle done strobe; the receiver cannot stall,
// so the result must be taken in that cycle. A remove (func 1) returns nothing. Entries sit
// in a 4096-deep open-addressed memory (linear probing, removed entries leave tombstones).
// Each probe passes through S_PROBE (registered memory read) and then S_CHECK (compare); a
// transaction may probe up to 4096 slots when the table is crowded with live or removed
// entries. A request for source zero is answered from the idle state without probing. After
// reset a clearing pass writes all 4096 entries empty; busy stays high during it.
module per_source_sequence_id_table
    import psid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [31:0] source_id,
    output logic        done,
    output logic [31:0] event_id,
    output logic [1:0]  status
);

    entry_t mem [CAPACITY];

    fsm_t             state_reg, state_next;
    logic [IDX_W-1:0] addr_reg, addr_next;       // probe / clear address
    logic [CNT_W-1:0] probes_reg, probes_next;   // probes done so far
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic             tomb_seen_reg, tomb_seen_next;
    logic [IDX_W-1:0] tomb_addr_reg, tomb_addr_next;
    logic             func_reg, func_next;
    logic [31:0]      src_reg, src_next;
    logic             done_reg, done_next;
    logic [31:0]      id_reg, id_next;
    logic [1:0]       status_reg, status_next;

    entry_t           rd_data_reg;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    logic             hit;
    logic             last_probe;
    logic [31:0]      cnt_inc;

    // memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            probes_reg    <= '0;
            occ_reg       <= '0;
            tomb_seen_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            probes_reg    <= probes_next;
            occ_reg       <= occ_next;
            tomb_seen_reg <= tomb_seen_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tomb_addr_reg <= tomb_addr_next;
        func_reg      <= func_next;
        src_reg       <= src_next;
        id_reg        <= id_next;
        status_reg    <= status_next;
    end

    // shared compare and increment
    assign hit        = (rd_data_reg.tag == TAG_USED) && (rd_data_reg.key == src_reg);
    assign last_probe = (probes_reg == CNT_W'(CAPACITY - 1));
    assign cnt_inc    = (rd_data_reg.count == 32'hFFFF_FFFF) ? 32'd1
                                                             : rd_data_reg.count + 32'd1;

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        probes_next    = probes_reg;
        occ_next       = occ_reg;
        tomb_seen_next = tomb_seen_reg;
        tomb_addr_next = tomb_addr_reg;
        func_next      = func_reg;
        src_next       = src_reg;
        done_next      = 1'b0;
        id_next        = id_reg;
        status_next    = status_reg;
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_data        = '{tag: TAG_EMPTY, key: 32'd0, count: 32'd0};

        case (state_reg)
            S_CLEAR:
            begin
                wr_en     = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == IDX_W'(CAPACITY - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    func_next      = func;
                    src_next       = source_id;
                    addr_next      = home_slot(source_id);
                    probes_next    = '0;
                    tomb_seen_next = 1'b0;
                    if (source_id == 32'd0)
                    begin
                        if (func == FUNC_REQUEST)
                        begin
                            done_next   = 1'b1;
                            id_next     = 32'd0;
                            status_next = ST_ZERO_SOURCE;
                        end
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                // read of addr_reg is in flight
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (hit)
                begin
                    state_next = S_IDLE;
                    wr_en      = 1'b1;
                    if (func_reg == FUNC_REMOVE)
                    begin
                        wr_data  = '{tag: TAG_TOMB, key: src_reg, count: 32'd0};
                        occ_next = occ_reg - 1'b1;
                    end
                    else
                    begin
                        wr_data     = '{tag: TAG_USED, key: src_reg, count: cnt_inc};
                        done_next   = 1'b1;
                        id_next     = cnt_inc;
                        status_next = ST_OK;
                    end
                end
                else if (rd_data_reg.tag == TAG_EMPTY || last_probe)
                begin
                    // source absent
                    state_next = S_IDLE;
                    if (func_reg == FUNC_REQUEST)
                    begin
                        done_next = 1'b1;
                        if (occ_reg == CNT_W'(CAPACITY))
                        begin
                            id_next     = 32'd0;
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = tomb_seen_reg ? tomb_addr_reg : addr_reg;
                            wr_data     = '{tag: TAG_USED, key: src_reg, count: 32'd1};
                            occ_next    = occ_reg + 1'b1;
                            id_next     = 32'd1;
                            status_next = ST_OK;
                        end
                    end
                end
                else
                begin
                    if (rd_data_reg.tag == TAG_TOMB && !tomb_seen_reg)
                    begin
                        tomb_seen_next = 1'b1;
                        tomb_addr_next = addr_reg;
                    end
                    addr_next   = addr_reg + 1'b1;
                    probes_next = probes_reg + 1'b1;
                    state_next  = S_PROBE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign event_id = id_reg;
    assign status   = status_reg;

endmodule

### bench/testbench.sv
// Self-checking testbench for per_source_sequence_id_table: directed, random and table-full tests.
// Depends on psid_pkg and the per_source_sequence_id_table RTL.
module testbench
    import psid_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        func;
    logic [31:0] source_id;
    logic        busy;
    logic        done;
    logic [31:0] event_id;
    logic [1:0]  status;

    // One expected answer for a request transaction.
    typedef struct {
        logic [31:0] event_id;
        status_t     status;
    } id_answer_t;

    // Own copy of the table: live sources and their counters.
    logic [31:0] seq_count [logic [31:0]];
    id_answer_t  pending_answers [$];

    int errors;
    int sent_count;
    int request_count;
    int remove_count;
    int full_rejects;
    int idle_cycles;
    int idle_pct;
    bit fail_seen;

    localparam int WATCHDOG_LIMIT = 120000;

    per_source_sequence_id_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .source_id (source_id),
        .done      (done),
        .event_id  (event_id),
        .status    (status)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Apply one transaction to the table copy; returns 1 when a result is due.
    function automatic bit predict_next_id(input func_t op, input logic [31:0] src,
                                           output id_answer_t ans);
        logic [31:0] next;
        ans.event_id = '0;
        ans.status   = ST_OK;
        if (op == FUNC_REMOVE)
        begin
            // removes of source zero or of absent sources change nothing
            if (src != 0 && seq_count.exists(src))
                seq_count.delete(src);
            return 1'b0;
        end
        if (src == 0)
        begin
            ans.status = ST_ZERO_SOURCE;
            return 1'b1;
        end
        if (!seq_count.exists(src))
        begin
            if (seq_count.num() >= CAPACITY)
            begin
                ans.status = ST_FULL;
                return 1'b1;
            end
            seq_count[src] = '0;
        end
        next = seq_count[src] + 32'd1;
        // counter skips zero on wrap
        if (next == 0)
            next = 32'd1;
        seq_count[src] = next;
        ans.event_id   = next;
        return 1'b1;
    endfunction

    // Present one transaction and hold it until the block takes it.
    // start is left high; the caller lowers it with idle_for or wait_drain.
    task automatic send_item(input func_t op, input logic [31:0] src);
        id_answer_t ans;
        start     <= 1'b1;
        func      <= op;
        source_id <= src;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (predict_next_id(op, src, ans))
        begin
            pending_answers.push_back(ans);
            if (ans.status == ST_FULL)
                full_rejects++;
        end
        sent_count++;
        if (op == FUNC_REMOVE)
            remove_count++;
        else
            request_count++;
    endtask

    task automatic idle_for(input int n);
        start <= 1'b0;
        repeat (n)
            @(posedge clk);
    endtask

    // Random gap after a transaction, per the current idle percentage.
    task automatic maybe_idle();
        if ($urandom_range(99) < idle_pct)
        begin
            idle_for($urandom_range(1, 6));
            idle_cycles++;
        end
    endtask

    // Sender pauses until every answer is in and the block is idle again.
    task automatic wait_drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0 || busy)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
    endtask

    // Checker: done is sampled at the edge that ends the result cycle.
    always @(posedge clk)
    begin
        id_answer_t exp_ans;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual event_id=%h status=%0d",
                         $time, event_id, status);
                errors++;
            end
            else
            begin
                exp_ans = pending_answers.pop_front();
                if (event_id !== exp_ans.event_id)
                begin
                    $display("%0t: event_id mismatch: expected %h, actual %h",
                             $time, exp_ans.event_id, event_id);
                    errors++;
                end
                if (status !== exp_ans.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, exp_ans.status, status);
                    errors++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which work is outstanding but no transaction and no result is accepted.
    always @(posedge clk)
    begin
        int quiet;
        if (!rst_n || (start && !busy) || done || (pending_answers.size() == 0 && !start))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d answers pending",
                     $time, pending_answers.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Field extremes, both operations and the special cases short of a full table by hand.
    task automatic test_directed();
        send_item(FUNC_REQUEST, 32'h0000_0000);   // source zero rejected
        send_item(FUNC_REQUEST, 32'hFFFF_FFFF);
        send_item(FUNC_REQUEST, 32'hFFFF_FFFF);
        send_item(FUNC_REQUEST, 32'h0000_0001);
        send_item(FUNC_REQUEST, 32'h8000_0000);
        send_item(FUNC_REQUEST, 32'hFFFF_FFFF);
        send_item(FUNC_REMOVE,  32'hFFFF_FFFF);
        send_item(FUNC_REQUEST, 32'hFFFF_FFFF);   // counts restart after remove
        send_item(FUNC_REMOVE,  32'h0000_0000);   // ignored
        send_item(FUNC_REMOVE,  32'h1234_5678);   // absent, ignored
        send_item(FUNC_REQUEST, 32'h0000_0001);
        send_item(FUNC_REQUEST, 32'h1234_5678);
        send_item(FUNC_REQUEST, 32'h0000_1000);   // same home slot as key 1
        send_item(FUNC_REQUEST, 32'h0000_0001);
        send_item(FUNC_REMOVE,  32'h0000_0001);
        send_item(FUNC_REQUEST, 32'h0000_1000);   // probe past the removed entry
        send_item(FUNC_REQUEST, 32'h0000_0001);
        send_item(FUNC_REQUEST, 32'h0000_0000);
        wait_drain();
    endtask

    // Mostly a small pool of sources so counters climb; some fresh random sources.
    task automatic test_random(input int n);
        logic [31:0] pool [48];
        logic [31:0] src;
        func_t       op;
        int          i;
        for (i = 0; i < 48; i++)
            pool[i] = $urandom();
        pool[0] = 32'h0000_0000;
        pool[1] = 32'hFFFF_FFFF;
        pool[2] = 32'h0000_0001;
        for (i = 0; i < n; i++)
        begin
            // a long stretch in the middle without any gaps
            idle_pct = (i > n / 3 && i < n / 2) ? 0 : 33;
            if ($urandom_range(99) < 75)
                src = pool[$urandom_range(47)];
            else
                src = $urandom();
            op = ($urandom_range(99) < 25) ? FUNC_REMOVE : FUNC_REQUEST;
            send_item(op, src);
            maybe_idle();
            if (i == n / 2)
                wait_drain();
        end
        wait_drain();
    endtask

    // Fill the table to capacity, then check rejection and recovery.
    task automatic test_table_full();
        logic [31:0] key;
        key = 32'd1;
        idle_pct = 10;
        while (seq_count.num() < CAPACITY)
        begin
            if (!seq_count.exists(key))
            begin
                send_item(FUNC_REQUEST, key);
                maybe_idle();
            end
            key++;
        end
        send_item(FUNC_REQUEST, 32'hDEAD_BEEF);   // absent, table full
        send_item(FUNC_REQUEST, 32'h0000_0001);   // present, still served
        send_item(FUNC_REQUEST, 32'h0000_0000);
        send_item(FUNC_REQUEST, 32'hCAFE_0000);
        send_item(FUNC_REMOVE,  32'h0000_0002);
        send_item(FUNC_REQUEST, 32'hCAFE_0000);   // free slot again
        send_item(FUNC_REQUEST, 32'hDEAD_BEEF);   // full once more
        wait_drain();
    endtask

    initial
    begin
        errors        = 0;
        sent_count    = 0;
        request_count = 0;
        remove_count  = 0;
        full_rejects  = 0;
        idle_cycles   = 0;
        idle_pct      = 33;
        rst_n         = 1'b0;
        start         = 1'b0;
        func          = FUNC_REQUEST;
        source_id     = '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(1950);
        test_table_full();

        if (pending_answers.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, pending_answers.size());
            errors++;
        end
        $display("Sent %0d transactions (%0d requests, %0d removes), %0d table-full rejects,",
                 sent_count, request_count, remove_count, full_rejects);
        $display("with %0d random sender gaps; %0d mismatches found.", idle_cycles, errors);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
